/* rtl/assert_macros.svh */
// ----------------------------------------------------------------------------
// Assertion macros used by the RTL files
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Concurrent check on the rising clock edge, off while reset is low
`define ASSERT_CLK_RST(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (prop)) else $error(msg);

// Concurrent check on the rising clock edge, active during reset too
`define ASSERT_CLK(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

/* rtl/stsra_pkg.sv */
// ----------------------------------------------------------------------------
// stsra_pkg
// Widths, command codes and payload types of the sparse row accumulator.
// ----------------------------------------------------------------------------
package stsra_pkg;

    localparam int IDX_W   = 12;   // source and row index width
    localparam int VAL_W   = 24;   // Q3.20 moment and tensor values
    localparam int PROD_W  = 48;   // Q7.40 product
    localparam int TERM_W  = 50;   // sum of three products
    localparam int FIELD_W = 56;   // Q15.40 accumulator

    // Command codes of an input item
    typedef enum logic [1:0] {
        CMD_LOAD  = 2'd0,
        CMD_ENTRY = 2'd1,
        CMD_EMPTY = 2'd2
    } t_cmd;

    // One stored dipole moment
    typedef struct packed {
        logic signed [VAL_W-1:0] x;
        logic signed [VAL_W-1:0] y;
        logic signed [VAL_W-1:0] z;
    } t_moment;

    // One result item
    typedef struct packed {
        logic [IDX_W-1:0]          row_number;
        logic signed [FIELD_W-1:0] field_x;
        logic signed [FIELD_W-1:0] field_y;
        logic signed [FIELD_W-1:0] field_z;
        logic                      saturated;
    } t_result;

endpackage

/* rtl/stsra_in_if.sv */
// ----------------------------------------------------------------------------
// stsra_in_if
// Input channel: valid/ready handshake with one command item.
// ----------------------------------------------------------------------------
interface stsra_in_if import stsra_pkg::*; ;

    logic                    valid;
    logic                    ready;
    logic [1:0]              command;
    logic [IDX_W-1:0]        source_index;
    logic signed [VAL_W-1:0] value_a;
    logic signed [VAL_W-1:0] value_b;
    logic signed [VAL_W-1:0] value_c;
    logic signed [VAL_W-1:0] value_d;
    logic signed [VAL_W-1:0] value_e;
    logic signed [VAL_W-1:0] value_f;
    logic                    skip_self;
    logic [IDX_W-1:0]        self_index;
    logic                    last_in_row;

    modport source (
        output valid, command, source_index, value_a, value_b, value_c,
               value_d, value_e, value_f, skip_self, self_index, last_in_row,
        input  ready
    );

    modport sink (
        input  valid, command, source_index, value_a, value_b, value_c,
               value_d, value_e, value_f, skip_self, self_index, last_in_row,
        output ready
    );

endinterface

/* rtl/stsra_out_if.sv */
// ----------------------------------------------------------------------------
// stsra_out_if
// Output channel: valid/ready handshake with one row result item.
// ----------------------------------------------------------------------------
interface stsra_out_if import stsra_pkg::*; ;

    logic                      valid;
    logic                      ready;
    logic [IDX_W-1:0]          row_number;
    logic signed [FIELD_W-1:0] field_x;
    logic signed [FIELD_W-1:0] field_y;
    logic signed [FIELD_W-1:0] field_z;
    logic                      saturated;

    modport source (
        output valid, row_number, field_x, field_y, field_z, saturated,
        input  ready
    );

    modport sink (
        input  valid, row_number, field_x, field_y, field_z, saturated,
        output ready
    );

endinterface

/* rtl/symmetric_tensor_sparse_row_accumulate.sv */
// ----------------------------------------------------------------------------
// symmetric_tensor_sparse_row_accumulate
// Streams CSR rows of symmetric 3x3 tensor blocks against stored moments.
// ----------------------------------------------------------------------------
// Takes one item per clock while ready is high. Loads write the moment memory
// at the accept edge; an entry reads it at its own accept edge, so an entry may
// follow the load of its source directly. An entry goes through three register
// stages (moment read, nine 24x24 products, three-product sums) and is then
// added into the saturating 56-bit row sums; the row result is registered into
// the output result register or skid entry as the item that closed the row
// leaves the sum stage. The output has a result register and one skid entry;
// input ready drops only while the skid entry is occupied, and the whole
// pipeline holds in that cycle. The moment memory is not cleared after reset:
// an entry must only use a source that was loaded before.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module symmetric_tensor_sparse_row_accumulate
    import stsra_pkg::*;
#(
    parameter int SOURCE_DEPTH = 4096,
    parameter int TARGET_ROWS  = 4096
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_cfg_we,
    input  logic            i_cfg_wdata,
    stsra_in_if.sink        i_in,
    stsra_out_if.source     o_out
);

    // Compare width covers the largest depth and row count (65536)
    localparam int CMP_W      = 17;
    localparam int SRC_AW     = (SOURCE_DEPTH > 1) ? $clog2(SOURCE_DEPTH) : 1;
    localparam int SRC_WIDE_W = SRC_AW + IDX_W;
    localparam int ACC_W      = FIELD_W + 1;

    // ---------------- configuration ----------------
    logic r_self_check;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_self_check <= 1'b1;
        end else if (i_cfg_we) begin
            r_self_check <= i_cfg_wdata;
        end
    end

    // ---------------- input decode ----------------
    logic                  r_skid_v;
    logic                  en;
    logic                  accept;
    logic [SRC_WIDE_W-1:0] src_wide;
    logic [SRC_AW-1:0]     src_addr;
    logic                  src_in_range;
    logic                  is_load;
    logic                  is_entry;
    logic                  self_hit;
    logic                  in_act;
    logic                  in_close;

    assign en          = !r_skid_v;
    assign i_in.ready  = en;
    assign accept      = i_in.valid && en;

    assign src_wide     = SRC_WIDE_W'(i_in.source_index);
    assign src_addr     = src_wide[SRC_AW-1:0];
    assign src_in_range = (CMP_W'(i_in.source_index) < CMP_W'(SOURCE_DEPTH));

    assign is_load  = (i_in.command == CMD_LOAD);
    assign is_entry = (i_in.command == CMD_ENTRY);
    assign self_hit = i_in.skip_self && r_self_check
                      && (i_in.source_index == i_in.self_index);
    assign in_act   = is_entry && src_in_range && !self_hit;
    assign in_close = (is_entry && i_in.last_in_row) || (i_in.command == CMD_EMPTY);

    // ---------------- moment memory ----------------
    t_moment r_mem [SOURCE_DEPTH];
    t_moment r_mom_q;

    always_ff @(posedge i_clk) begin
        if (accept && is_load && src_in_range) begin
            r_mem[src_addr] <= '{x: i_in.value_a, y: i_in.value_b, z: i_in.value_c};
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_mom_q <= r_mem[src_addr];
        end
    end

    // ---------------- stage 1: tensor and flags ----------------
    logic                    r_p1_v;
    logic                    r_p1_act;
    logic                    r_p1_close;
    logic signed [VAL_W-1:0] r_t_xx, r_t_xy, r_t_xz, r_t_yy, r_t_yz, r_t_zz;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_p1_v <= 1'b0;
        end else if (en) begin
            r_p1_v <= accept && (in_act || in_close);
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_p1_act   <= in_act;
            r_p1_close <= in_close;
            r_t_xx     <= i_in.value_a;
            r_t_xy     <= i_in.value_b;
            r_t_xz     <= i_in.value_c;
            r_t_yy     <= i_in.value_d;
            r_t_yz     <= i_in.value_e;
            r_t_zz     <= i_in.value_f;
        end
    end

    // ---------------- stage 2: nine products ----------------
    logic                     r_p2_v;
    logic                     r_p2_act;
    logic                     r_p2_close;
    logic signed [PROD_W-1:0] r_prod [9];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_p2_v <= 1'b0;
        end else if (en) begin
            r_p2_v <= r_p1_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_p2_act   <= r_p1_act;
            r_p2_close <= r_p1_close;
            // row x: xx*mx + xy*my + xz*mz
            r_prod[0]  <= r_t_xx * r_mom_q.x;
            r_prod[1]  <= r_t_xy * r_mom_q.y;
            r_prod[2]  <= r_t_xz * r_mom_q.z;
            // row y: xy*mx + yy*my + yz*mz
            r_prod[3]  <= r_t_xy * r_mom_q.x;
            r_prod[4]  <= r_t_yy * r_mom_q.y;
            r_prod[5]  <= r_t_yz * r_mom_q.z;
            // row z: xz*mx + yz*my + zz*mz
            r_prod[6]  <= r_t_xz * r_mom_q.x;
            r_prod[7]  <= r_t_yz * r_mom_q.y;
            r_prod[8]  <= r_t_zz * r_mom_q.z;
        end
    end

    // ---------------- stage 3: per-axis terms ----------------
    logic                     r_p3_v;
    logic                     r_p3_act;
    logic                     r_p3_close;
    logic signed [TERM_W-1:0] r_term_x, r_term_y, r_term_z;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_p3_v <= 1'b0;
        end else if (en) begin
            r_p3_v <= r_p2_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_p3_act   <= r_p2_act;
            r_p3_close <= r_p2_close;
            r_term_x   <= TERM_W'(r_prod[0]) + TERM_W'(r_prod[1]) + TERM_W'(r_prod[2]);
            r_term_y   <= TERM_W'(r_prod[3]) + TERM_W'(r_prod[4]) + TERM_W'(r_prod[5]);
            r_term_z   <= TERM_W'(r_prod[6]) + TERM_W'(r_prod[7]) + TERM_W'(r_prod[8]);
        end
    end

    // ---------------- accumulate with saturation ----------------
    logic signed [FIELD_W-1:0] r_sum_x, r_sum_y, r_sum_z;
    logic                      r_clip;
    logic [IDX_W-1:0]          r_row;

    logic signed [ACC_W-1:0]   raw_x, raw_y, raw_z;
    logic signed [FIELD_W-1:0] n_sum_x, n_sum_y, n_sum_z;
    logic                      ovf_x, ovf_y, ovf_z;
    logic                      n_clip;
    logic [CMP_W-1:0]          row_inc;
    logic [IDX_W-1:0]          n_row;
    logic                      close_now;
    t_result                   new_res;

    // Clamp a 57-bit sum to the signed 56-bit range
    function automatic logic signed [FIELD_W-1:0] sat56(input logic signed [ACC_W-1:0] v);
        logic signed [FIELD_W-1:0] lim;
        lim = {v[ACC_W-1], {(FIELD_W-1){~v[ACC_W-1]}}};
        return (v[ACC_W-1] != v[ACC_W-2]) ? lim : v[FIELD_W-1:0];
    endfunction

    always_comb begin
        raw_x   = ACC_W'(r_sum_x) + ACC_W'(r_term_x);
        raw_y   = ACC_W'(r_sum_y) + ACC_W'(r_term_y);
        raw_z   = ACC_W'(r_sum_z) + ACC_W'(r_term_z);
        ovf_x   = raw_x[ACC_W-1] != raw_x[ACC_W-2];
        ovf_y   = raw_y[ACC_W-1] != raw_y[ACC_W-2];
        ovf_z   = raw_z[ACC_W-1] != raw_z[ACC_W-2];
        n_sum_x = r_sum_x;
        n_sum_y = r_sum_y;
        n_sum_z = r_sum_z;
        n_clip  = r_clip;
        if (r_p3_act) begin
            n_sum_x = sat56(raw_x);
            n_sum_y = sat56(raw_y);
            n_sum_z = sat56(raw_z);
            n_clip  = r_clip || ovf_x || ovf_y || ovf_z;
        end
        // row counter wraps at the row count and at its own width
        row_inc = CMP_W'(r_row) + CMP_W'(1);
        n_row   = (row_inc >= CMP_W'(TARGET_ROWS)) ? '0 : row_inc[IDX_W-1:0];
        close_now = en && r_p3_v && r_p3_close;
        new_res = '{row_number: r_row, field_x: n_sum_x, field_y: n_sum_y,
                    field_z: n_sum_z, saturated: n_clip};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sum_x <= '0;
            r_sum_y <= '0;
            r_sum_z <= '0;
            r_clip  <= 1'b0;
            r_row   <= '0;
        end else if (en && r_p3_v) begin
            if (r_p3_close) begin
                r_sum_x <= '0;
                r_sum_y <= '0;
                r_sum_z <= '0;
                r_clip  <= 1'b0;
                r_row   <= n_row;
            end else begin
                r_sum_x <= n_sum_x;
                r_sum_y <= n_sum_y;
                r_sum_z <= n_sum_z;
                r_clip  <= n_clip;
            end
        end
    end

    // ---------------- result register and skid entry ----------------
    logic    r_out_v;
    t_result r_out;
    t_result r_skid;
    logic    take;

    assign take = r_out_v && o_out.ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_v  <= 1'b0;
            r_skid_v <= 1'b0;
        end else if (r_skid_v) begin
            if (take) begin
                r_skid_v <= 1'b0;
            end
        end else if (close_now) begin
            if (!r_out_v || take) begin
                r_out_v <= 1'b1;
            end else begin
                r_skid_v <= 1'b1;
            end
        end else if (take) begin
            r_out_v <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_skid_v) begin
            if (take) begin
                r_out <= r_skid;
            end
        end else if (close_now) begin
            if (!r_out_v || take) begin
                r_out <= new_res;
            end else begin
                r_skid <= new_res;
            end
        end
    end

    assign o_out.valid      = r_out_v;
    assign o_out.row_number = r_out.row_number;
    assign o_out.field_x    = r_out.field_x;
    assign o_out.field_y    = r_out.field_y;
    assign o_out.field_z    = r_out.field_z;
    assign o_out.saturated  = r_out.saturated;

    // ---------------- assertions ----------------
    `ASSERT_CLK_RST(a_skid_needs_out, i_clk, i_rst_n, r_skid_v |-> r_out_v, "skid entry held while result register empty")
    `ASSERT_CLK_RST(a_close_clears, i_clk, i_rst_n, close_now |=> (r_sum_x == '0 && r_sum_y == '0 && r_sum_z == '0 && !r_clip), "row sums not cleared after row close")
    `ASSERT_CLK_RST(a_stall_holds, i_clk, i_rst_n, !en |=> ($stable(r_sum_x) && $stable(r_row) && $stable(r_p3_v)), "pipeline moved during output stall")

endmodule

/* tb/sv/symmetric_tensor_sparse_row_accumulate_test.sv */
// ----------------------------------------------------------------------------
// symmetric_tensor_sparse_row_accumulate_test
// Self-checking bench for the sparse row accumulator. A queue-fed driver
// streams moment loads, row entries and empty rows with random gaps; a
// predictor tracks the moment store, saturating row sums and row counter, and
// a monitor compares every row result, field by field, in order.
// ----------------------------------------------------------------------------
module symmetric_tensor_sparse_row_accumulate_test;
    import stsra_pkg::*;

    localparam int SOURCE_DEPTH = 4096;
    localparam int TARGET_ROWS  = 4096;
    localparam int CYCLE_LIMIT  = 800000;
    localparam int HOLD_CYCLES  = 400;
    localparam int DRAIN_CYCLES = 8;
    localparam int CLIP_LEN     = 185;

    // command code the block must ignore
    localparam logic [1:0] CMD_UNUSED = 2'd3;

    localparam logic signed [VAL_W-1:0] Q_MAX = {1'b0, {(VAL_W-1){1'b1}}};
    localparam logic signed [VAL_W-1:0] Q_MIN = {1'b1, {(VAL_W-1){1'b0}}};
    localparam longint ACC_HI = (longint'(1) <<< (FIELD_W-1)) - 1;
    localparam longint ACC_LO = -ACC_HI - 1;

    typedef logic signed [VAL_W-1:0] t_six [6];

    // one input item; val[0..5] = a..f
    typedef struct {
        logic [1:0]              command;
        logic [IDX_W-1:0]        source_index;
        logic signed [VAL_W-1:0] val [6];
        logic                    skip_self;
        logic [IDX_W-1:0]        self_index;
        logic                    last_in_row;
    } t_item;

    logic clk;
    logic rst_n;
    logic cfg_we;
    logic cfg_wdata;

    stsra_in_if  in_ch ();
    stsra_out_if out_ch ();

    symmetric_tensor_sparse_row_accumulate #(
        .SOURCE_DEPTH (SOURCE_DEPTH),
        .TARGET_ROWS  (TARGET_ROWS)
    ) u_top (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_cfg_we    (cfg_we),
        .i_cfg_wdata (cfg_wdata),
        .i_in        (in_ch),
        .o_out       (out_ch)
    );

    // queues between stimulus, driver and monitor
    t_item   pend_q [$];
    t_result row_sum_q [$];

    // predictor state
    t_moment          mom_store [SOURCE_DEPTH];
    longint           acc_x, acc_y, acc_z;
    bit               acc_clip;
    logic [IDX_W-1:0] row_cnt;
    bit               self_check;

    // stimulus bookkeeping
    bit  src_loaded [SOURCE_DEPTH];
    int  loaded_q [$];
    int  gen_items;
    int  rows_planned;

    // handshake pacing
    bit  in_busy;
    int  src_gap;
    bit  src_calm;
    bit  src_force;
    int  sink_wait;
    bit  sink_calm;
    bit  stall_req;
    int  hold_left;

    // run statistics
    int  cycle_cnt;
    int  err_cnt;
    int  n_loads, n_entries, n_empty, n_wraps, n_cfg;
    int  rows_seen, rows_clipped;

    // clock
    always begin
        clk = 1'b1;
        #5;
        clk = 1'b0;
        #5;
    end

    // ------------------------------------------------------------------
    // Predictor
    // ------------------------------------------------------------------
    function automatic longint sat_acc(longint acc, longint term);
        longint s;
        s = acc + term;
        if (s > ACC_HI) begin
            acc_clip = 1'b1;
            return ACC_HI;
        end
        if (s < ACC_LO) begin
            acc_clip = 1'b1;
            return ACC_LO;
        end
        return s;
    endfunction

    // apply one accepted item; returns 1 when it closes a row
    function automatic bit fold_item(input t_item it, output t_result res);
        longint m [3];
        longint t [6];
        bit     done;
        res  = '0;
        done = 1'b0;
        case (it.command)
            CMD_LOAD: begin
                mom_store[it.source_index] = '{x: it.val[0], y: it.val[1], z: it.val[2]};
                n_loads++;
            end
            CMD_ENTRY: begin
                n_entries++;
                if (!(it.skip_self && self_check && it.source_index == it.self_index)) begin
                    m[0] = $signed(mom_store[it.source_index].x);
                    m[1] = $signed(mom_store[it.source_index].y);
                    m[2] = $signed(mom_store[it.source_index].z);
                    for (int k = 0; k < 6; k++) t[k] = it.val[k];
                    // symmetric tensor [a b c; b d e; c e f] times moment
                    acc_x = sat_acc(acc_x, t[0] * m[0] + t[1] * m[1] + t[2] * m[2]);
                    acc_y = sat_acc(acc_y, t[1] * m[0] + t[3] * m[1] + t[4] * m[2]);
                    acc_z = sat_acc(acc_z, t[2] * m[0] + t[4] * m[1] + t[5] * m[2]);
                end
                done = it.last_in_row;
            end
            CMD_EMPTY: begin
                n_empty++;
                done = 1'b1;
            end
            default: ;
        endcase
        if (done) begin
            res.row_number = row_cnt;
            res.field_x    = acc_x[FIELD_W-1:0];
            res.field_y    = acc_y[FIELD_W-1:0];
            res.field_z    = acc_z[FIELD_W-1:0];
            res.saturated  = acc_clip;
            acc_x    = 0;
            acc_y    = 0;
            acc_z    = 0;
            acc_clip = 1'b0;
            if (row_cnt == TARGET_ROWS - 1) begin
                row_cnt = '0;
                n_wraps++;
            end else begin
                row_cnt++;
            end
        end
        return done;
    endfunction

    // ------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------
    function automatic logic signed [VAL_W-1:0] rand_q320();
        case ($urandom_range(0, 7))
            0:       return Q_MAX;
            1:       return Q_MIN;
            2:       return VAL_W'($urandom_range(0, 63)) - 32;
            default: return VAL_W'($urandom);
        endcase
    endfunction

    function automatic t_six rand_six();
        t_six v;
        for (int k = 0; k < 6; k++) v[k] = rand_q320();
        return v;
    endfunction

    // item with every field random, command given
    function automatic t_item noise_item(logic [1:0] cmd);
        t_item it;
        it.command      = cmd;
        it.source_index = IDX_W'($urandom);
        for (int k = 0; k < 6; k++) it.val[k] = VAL_W'($urandom);
        it.skip_self    = 1'($urandom);
        it.self_index   = IDX_W'($urandom);
        it.last_in_row  = 1'($urandom);
        return it;
    endfunction

    function automatic int pick_loaded();
        return loaded_q[$urandom_range(0, loaded_q.size() - 1)];
    endfunction

    task automatic push_load(int src, logic signed [VAL_W-1:0] mx,
                             logic signed [VAL_W-1:0] my, logic signed [VAL_W-1:0] mz);
        t_item it;
        it = noise_item(CMD_LOAD);
        it.source_index = IDX_W'(src);
        it.val[0] = mx;
        it.val[1] = my;
        it.val[2] = mz;
        pend_q.push_back(it);
        gen_items++;
        if (!src_loaded[src]) begin
            src_loaded[src] = 1'b1;
            loaded_q.push_back(src);
        end
    endtask

    task automatic push_entry(int src, t_six tv, bit skip, int self_idx, bit last);
        t_item it;
        it = noise_item(CMD_ENTRY);
        it.source_index = IDX_W'(src);
        for (int k = 0; k < 6; k++) it.val[k] = tv[k];
        it.skip_self   = skip;
        it.self_index  = IDX_W'(self_idx);
        it.last_in_row = last;
        pend_q.push_back(it);
        gen_items++;
        if (last) rows_planned++;
    endtask

    task automatic push_empty();
        pend_q.push_back(noise_item(CMD_EMPTY));
        gen_items++;
        rows_planned++;
    endtask

    // wait until nothing is queued, offered or outstanding
    task automatic drain();
        while (pend_q.size() != 0 || in_busy || row_sum_q.size() != 0) @(posedge clk);
    endtask

    task automatic set_self_check(bit v);
        drain();
        repeat (DRAIN_CYCLES) @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_wdata <= v;
        self_check = v;
        n_cfg++;
        @(posedge clk);
        cfg_we    <= 1'b0;
    endtask

    // mostly well-formed rows with random content, plus loads and noise
    task automatic random_traffic(int n);
        int  goal;
        int  len;
        int  row_self;
        int  src;
        bit  last;
        goal = gen_items + n;
        while (gen_items < goal) begin
            case ($urandom_range(0, 19))
                0, 1, 2: push_load(IDX_W'($urandom), rand_q320(), rand_q320(), rand_q320());
                3:       push_empty();
                4:       pend_q.push_back(noise_item(CMD_UNUSED));
                default: begin
                    len      = $urandom_range(1, 6);
                    row_self = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 4095)
                                                           : pick_loaded();
                    for (int k = 0; k < len; k++) begin
                        if ($urandom_range(0, 7) == 0)
                            push_load(pick_loaded(), rand_q320(), rand_q320(), rand_q320());
                        src = (src_loaded[row_self] && $urandom_range(0, 2) == 0)
                              ? row_self : pick_loaded();
                        last = (k == len - 1);
                        // occasionally close the row with an empty-row command instead
                        if (last && $urandom_range(0, 9) == 0) begin
                            push_entry(src, rand_six(), 1'($urandom), row_self, 1'b0);
                            push_empty();
                        end else begin
                            push_entry(src, rand_six(), 1'($urandom), row_self, last);
                        end
                    end
                end
            endcase
        end
    endtask

    // long row of extreme terms that runs an accumulator into its clamp
    task automatic clip_row(bit negative);
        int   src;
        int   row_self;
        t_six hi;
        t_six lo;
        src      = $urandom_range(0, 4095);
        row_self = src ^ $urandom_range(1, 4095);
        hi       = '{Q_MAX, Q_MAX, Q_MAX, Q_MAX, Q_MAX, Q_MAX};
        lo       = '{Q_MIN, Q_MIN, Q_MIN, Q_MIN, Q_MIN, Q_MIN};
        if (negative) push_load(src, Q_MIN, Q_MIN, Q_MIN);
        else          push_load(src, Q_MAX, Q_MAX, Q_MAX);
        for (int k = 0; k < CLIP_LEN; k++)
            push_entry(src, hi, 1'($urandom), row_self, 1'b0);
        // back off the clamp a little; the sticky flag must stay set
        push_entry(src, lo, 1'b0, row_self, 1'b0);
        push_entry(src, lo, 1'b1, row_self, 1'b1);
    endtask

    // ------------------------------------------------------------------
    // Driver: one item per handshake, random gap after each
    // ------------------------------------------------------------------
    always @(posedge clk) begin : feed_proc
        t_item   cur_item;
        t_result res;
        if (!rst_n) begin
            in_busy = 1'b0;
            src_gap = 0;
            in_ch.valid <= 1'b0;
        end else begin
            if (in_busy && in_ch.ready) begin
                if (fold_item(cur_item, res)) row_sum_q.push_back(res);
                in_busy = 1'b0;
                src_gap = (src_calm || src_force) ? 0 : $urandom_range(0, 10);
            end
            if (!in_busy) begin
                if (src_gap > 0) begin
                    src_gap--;
                end else if (pend_q.size() != 0) begin
                    cur_item = pend_q.pop_front();
                    in_busy  = 1'b1;
                    in_ch.command      <= cur_item.command;
                    in_ch.source_index <= cur_item.source_index;
                    in_ch.value_a      <= cur_item.val[0];
                    in_ch.value_b      <= cur_item.val[1];
                    in_ch.value_c      <= cur_item.val[2];
                    in_ch.value_d      <= cur_item.val[3];
                    in_ch.value_e      <= cur_item.val[4];
                    in_ch.value_f      <= cur_item.val[5];
                    in_ch.skip_self    <= cur_item.skip_self;
                    in_ch.self_index   <= cur_item.self_index;
                    in_ch.last_in_row  <= cur_item.last_in_row;
                end
            end
            in_ch.valid <= in_busy;
        end
    end

    // ------------------------------------------------------------------
    // Long receiver hold-off, counted on its own
    // ------------------------------------------------------------------
    always @(posedge clk) begin
        if (!rst_n)              hold_left <= 0;
        else if (stall_req)      hold_left <= HOLD_CYCLES;
        else if (hold_left != 0) hold_left <= hold_left - 1;
    end

    // ------------------------------------------------------------------
    // Monitor: compare each row result with the oldest prediction
    // ------------------------------------------------------------------
    task automatic check_field(string name, logic [63:0] want, logic [63:0] got);
        if (want !== got) begin
            err_cnt++;
            if (err_cnt <= 10)
                $display("mismatch %s: expected %h, got %h", name, want, got);
        end
    endtask

    always @(posedge clk) begin : sink_proc
        t_result want;
        if (!rst_n) begin
            sink_wait = 0;
            out_ch.ready <= 1'b0;
        end else begin
            if (out_ch.valid && out_ch.ready) begin
                rows_seen++;
                if (out_ch.saturated) rows_clipped++;
                if (row_sum_q.size() == 0) begin
                    err_cnt++;
                    if (err_cnt <= 10)
                        $display("unexpected row result, row %0d", out_ch.row_number);
                end else begin
                    want = row_sum_q.pop_front();
                    check_field("row_number", want.row_number, out_ch.row_number);
                    check_field("field_x", want.field_x, out_ch.field_x);
                    check_field("field_y", want.field_y, out_ch.field_y);
                    check_field("field_z", want.field_z, out_ch.field_z);
                    check_field("saturated", want.saturated, out_ch.saturated);
                end
                sink_wait = sink_calm ? 0 : $urandom_range(0, 10);
            end else if (sink_wait > 0) begin
                sink_wait--;
            end
            out_ch.ready <= (sink_wait == 0) && (hold_left == 0);
        end
    end

    // ------------------------------------------------------------------
    // Cycle limit and pacing mode changes
    // ------------------------------------------------------------------
    always @(posedge clk) begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt % 97 == 0) begin
            src_calm  <= ($urandom_range(0, 3) == 0);
            sink_calm <= ($urandom_range(0, 3) == 0);
        end
        if (cycle_cnt == CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d rows outstanding",
                     cycle_cnt, row_sum_q.size());
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Test sequence
    // ------------------------------------------------------------------
    initial begin
        rst_n      = 1'b0;
        cfg_we     = 1'b0;
        cfg_wdata  = 1'b0;
        stall_req  = 1'b0;
        src_force  = 1'b0;
        src_calm   = 1'b0;
        sink_calm  = 1'b0;
        cycle_cnt  = 0;
        in_busy    = 1'b0;
        in_ch.valid        = 1'b0;
        in_ch.command      = CMD_LOAD;
        in_ch.source_index = '0;
        in_ch.value_a      = '0;
        in_ch.value_b      = '0;
        in_ch.value_c      = '0;
        in_ch.value_d      = '0;
        in_ch.value_e      = '0;
        in_ch.value_f      = '0;
        in_ch.skip_self    = 1'b0;
        in_ch.self_index   = '0;
        in_ch.last_in_row  = 1'b0;
        out_ch.ready       = 1'b0;
        acc_x      = 0;
        acc_y      = 0;
        acc_z      = 0;
        acc_clip   = 1'b0;
        row_cnt    = '0;
        self_check = 1'b1;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;

        // directed: extremes, skip rule, empty and mid-row close, ignored command
        set_self_check(1'b1);
        push_load(0, Q_MAX, Q_MAX, Q_MAX);
        push_load(4095, Q_MIN, Q_MIN, Q_MIN);
        push_load(12'hAAA, 24'sd1, -24'sd1, 24'sd0);
        push_entry(0, '{Q_MAX, Q_MAX, Q_MAX, Q_MAX, Q_MAX, Q_MAX}, 1'b0, 1, 1'b0);
        push_entry(4095, '{Q_MIN, Q_MIN, Q_MIN, Q_MIN, Q_MIN, Q_MIN}, 1'b0, 2, 1'b1);
        push_empty();
        push_entry(12'hAAA, rand_six(), 1'b1, 12'hAAA, 1'b1);
        push_entry(12'hAAA, rand_six(), 1'b1, 12'h555, 1'b0);
        push_entry(12'hAAA, rand_six(), 1'b0, 12'hAAA, 1'b1);
        pend_q.push_back(noise_item(CMD_UNUSED));
        // load with all row flags set: they must be ignored
        push_load(12'h555, 24'sh123456, -24'sh0ABCDE, 24'sh7F0001);
        pend_q[$].skip_self   = 1'b1;
        pend_q[$].self_index  = 12'h555;
        pend_q[$].last_in_row = 1'b1;
        push_entry(12'h555, rand_six(), 1'b1, 12'h555, 1'b0);
        push_entry(0, rand_six(), 1'b0, 0, 1'b0);
        push_empty();
        push_entry(0, '{0, 0, 0, 0, 0, 0}, 1'b0, 0, 1'b1);
        push_entry(4095, '{Q_MIN, Q_MAX, Q_MIN, Q_MAX, Q_MIN, Q_MAX}, 1'b0, 7, 1'b1);

        // self skip disabled
        set_self_check(1'b0);
        random_traffic(350);

        // receiver holds off while the sender streams short rows back to back
        set_self_check(1'b1);
        src_force = 1'b1;
        @(posedge clk);
        stall_req <= 1'b1;
        @(posedge clk);
        stall_req <= 1'b0;
        for (int k = 0; k < 60; k++) begin
            push_entry(pick_loaded(), rand_six(), 1'b0, 0, 1'b1);
            push_empty();
        end
        drain();
        src_force = 1'b0;
        random_traffic(250);

        // clamp at the negative end
        set_self_check(1'b0);
        clip_row(1'b1);
        random_traffic(200);

        // clamp at the positive end
        set_self_check(1'b1);
        clip_row(1'b0);
        random_traffic(150);
        random_traffic(40);

        drain();
        repeat (20) @(posedge clk);

        $display("covered %0d loads, %0d entries, %0d empty rows; %0d/%0d rows, %0d clipped",
                 n_loads, n_entries, n_empty, rows_seen, rows_planned, rows_clipped);
        $display("self check written %0d times, row counter wrapped %0d times, %0d errors",
                 n_cfg, n_wraps, err_cnt);
        if (err_cnt == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule
